### hw/rtl/pcrl_pkg.sv
// Shared types and constants for the priority ceiling resource lock.
package pcrl_pkg;

    localparam int RES_COUNT     = 8;
    localparam int TASK_COUNT    = 8;
    localparam int RES_ID_W      = 4;
    localparam int TASK_ID_W     = 3;
    localparam int PRIO_W        = 8;
    localparam int CFG_IDX_W     = 3;

    localparam logic [PRIO_W-1:0] CEIL_RESET = 8'd255;

    typedef enum logic
    {
        OP_GET     = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_ID     = 2'd1,
        ST_ACCESS = 2'd2,
        ST_NOFUNC = 2'd3
    } status_t;

    typedef struct packed
    {
        opcode_t               opcode;
        logic [RES_ID_W-1:0]   resource_id;
        logic [TASK_ID_W-1:0]  task_id;
        logic [PRIO_W-1:0]     task_priority;
        logic [PRIO_W-1:0]     base_priority;
        logic                  preemptible;
    } req_t;

    typedef struct packed
    {
        status_t               status;
        logic [PRIO_W-1:0]     new_priority;
        logic                  reschedule;
    } rsp_t;

endpackage

### hw/rtl/pcrl_if.sv
// Request, response and configuration channel interfaces.
interface pcrl_req_if;
    logic            valid;
    logic            ready;
    pcrl_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcrl_rsp_if;
    logic            valid;
    logic            ready;
    pcrl_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcrl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pcrl_pkg::CFG_IDX_W-1:0]     index;
    logic [pcrl_pkg::PRIO_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pcrl_cfg_regs.sv
// Ceiling priority registers, one per resource.
module pcrl_cfg_regs #(
    parameter int NUM_RESOURCES = pcrl_pkg::RES_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pcrl_cfg_if.sink                     cfg,
    output logic [pcrl_pkg::PRIO_W-1:0]  ceil [NUM_RESOURCES]
);

    localparam int RIW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

    logic [pcrl_pkg::PRIO_W-1:0] ceil_reg [NUM_RESOURCES];
    logic                        wr_en;

    assign cfg.ready = 1'b1;
    // indexes past the resource count are accepted and dropped
    assign wr_en = cfg.valid && (32'(cfg.index) < NUM_RESOURCES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                ceil_reg[i] <= pcrl_pkg::CEIL_RESET;
            end
        end
        else if (wr_en)
        begin
            ceil_reg[cfg.index[RIW-1:0]] <= cfg.data;
        end
    end

    assign ceil = ceil_reg;

endmodule

### hw/rtl/pcrl_core.sv
// Ownership and chain tables plus the get/release decision logic.
module pcrl_core #(
    parameter int NUM_RESOURCES = pcrl_pkg::RES_COUNT,
    parameter int NUM_TASKS     = pcrl_pkg::TASK_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  pcrl_pkg::req_t               item,
    input  logic [pcrl_pkg::PRIO_W-1:0]  ceil [NUM_RESOURCES],
    output pcrl_pkg::rsp_t               result
);

    localparam int RIW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // resource side: owner and the owner's previously held resource
    logic           owner_vld_reg [NUM_RESOURCES];
    logic [TIW-1:0] owner_task_reg [NUM_RESOURCES];
    logic           prev_vld_reg [NUM_RESOURCES];
    logic [RIW-1:0] prev_res_reg [NUM_RESOURCES];
    // task side: head of each task's chain
    logic           last_vld_reg [NUM_TASKS];
    logic [RIW-1:0] last_res_reg [NUM_TASKS];

    logic                        res_ok;
    logic                        task_ok;
    logic [RIW-1:0]              ridx;
    logic [TIW-1:0]              tidx;
    logic [pcrl_pkg::PRIO_W-1:0] ceil_r;
    logic [pcrl_pkg::PRIO_W-1:0] ceil_prev;
    logic                        own_vld;
    logic [TIW-1:0]              own_task;
    logic                        prv_vld;
    logic [RIW-1:0]              prv_res;
    logic                        lst_vld;
    logic [RIW-1:0]              lst_res;
    logic                        do_get;
    logic                        do_rel;

    assign res_ok  = 32'(item.resource_id) < NUM_RESOURCES;
    assign task_ok = 32'(item.task_id) < NUM_TASKS;
    assign ridx    = item.resource_id[RIW-1:0];
    assign tidx    = item.task_id[TIW-1:0];

    assign ceil_r    = ceil[ridx];
    assign own_vld   = owner_vld_reg[ridx];
    assign own_task  = owner_task_reg[ridx];
    assign prv_vld   = prev_vld_reg[ridx];
    assign prv_res   = prev_res_reg[ridx];
    assign lst_vld   = last_vld_reg[tidx];
    assign lst_res   = last_res_reg[tidx];
    assign ceil_prev = ceil[prv_res];

    always_comb
    begin
        result.status       = pcrl_pkg::ST_OK;
        result.new_priority = item.task_priority;
        result.reschedule   = 1'b0;
        do_get              = 1'b0;
        do_rel              = 1'b0;
        if (!res_ok || !task_ok)
        begin
            result.status = pcrl_pkg::ST_ID;
        end
        else if (item.opcode == pcrl_pkg::OP_GET)
        begin
            if (own_vld || (item.task_priority > ceil_r))
            begin
                result.status = pcrl_pkg::ST_ACCESS;
            end
            else
            begin
                result.new_priority = ceil_r;
                do_get              = 1'b1;
            end
        end
        else
        begin
            // out-of-order release only refused when the caller owns it
            if (!own_vld ||
                ((!lst_vld || (lst_res != ridx)) && (own_task == tidx)))
            begin
                result.status = pcrl_pkg::ST_NOFUNC;
            end
            else if (ceil_r < item.task_priority)
            begin
                result.status = pcrl_pkg::ST_ACCESS;
            end
            else
            begin
                result.new_priority = prv_vld ? ceil_prev : item.base_priority;
                result.reschedule   = item.preemptible;
                do_rel              = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                owner_vld_reg[i] <= 1'b0;
                prev_vld_reg[i]  <= 1'b0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                last_vld_reg[i] <= 1'b0;
            end
        end
        else if (fire)
        begin
            if (do_get)
            begin
                owner_vld_reg[ridx] <= 1'b1;
                prev_vld_reg[ridx]  <= lst_vld;
                last_vld_reg[tidx]  <= 1'b1;
            end
            else if (do_rel)
            begin
                owner_vld_reg[ridx] <= 1'b0;
                prev_vld_reg[ridx]  <= 1'b0;
                last_vld_reg[tidx]  <= prv_vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (do_get)
            begin
                owner_task_reg[ridx] <= tidx;
                prev_res_reg[ridx]   <= lst_res;
                last_res_reg[tidx]   <= ridx;
            end
            else if (do_rel)
            begin
                last_res_reg[tidx] <= prv_res;
            end
        end
    end

endmodule

### hw/rtl/priority_ceiling_resource_lock.sv
// Top level: request register, decision core, response register.
//
//  channel | dir | handshake     | beat carries
//  --------+-----+---------------+---------------------------------------------
//  req     | in  | valid/ready   | opcode, resource_id, task_id, priorities, flag
//  rsp     | out | valid/ready   | status, new_priority, reschedule
//  cfg     | in  | valid/ready   | index (ceiling register), data (ceiling)
//
// One request per cycle sustained while rsp is ready; a req beat goes into
// the request register, then one pass through the core into the response
// register, which raises rsp valid. Tables are flip-flops with valid bits,
// so they are usable straight after reset; ceilings reset to 255. A stalled
// rsp holds its beat, one further request waits in the request register,
// then req ready drops. cfg is always ready.
module priority_ceiling_resource_lock #(
    parameter int NUM_RESOURCES = pcrl_pkg::RES_COUNT,
    parameter int NUM_TASKS     = pcrl_pkg::TASK_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    pcrl_req_if.sink    req,
    pcrl_rsp_if.source  rsp,
    pcrl_cfg_if.sink    cfg
);

    logic                        in_vld_reg;
    pcrl_pkg::req_t              in_data_reg;
    logic                        out_vld_reg;
    pcrl_pkg::rsp_t              out_data_reg;
    logic                        advance;
    pcrl_pkg::rsp_t              core_result;
    logic [pcrl_pkg::PRIO_W-1:0] ceil [NUM_RESOURCES];

    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

    pcrl_cfg_regs #(
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ceil  (ceil)
    );

    pcrl_core #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .NUM_TASKS     (NUM_TASKS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .ceil   (ceil),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

endmodule
